// ----- rtl/cave_automaton_cell_update_core_macros.svh -----
// Assertion macros shared by the checker of the cave cell update core.
// Depends on nothing; every macro expands to one concurrent assertion.
`ifndef CAVE_AUTOMATON_CELL_UPDATE_CORE_MACROS_SVH
`define CAVE_AUTOMATON_CELL_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CACU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CACU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cacu_pkg.sv -----
// Shared types and codes of the cave cell update core.
// Used by the top level, the row tap and the checker; depends on nothing.
package cacu_pkg;

    // Item kinds; any other code behaves as a read.
    localparam logic [1:0] KIND_SEED   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_STATE     = 3'd4;

    // Largest neighbour count.
    localparam logic [3:0] MAX_NEIGHBOURS = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [6:0] col;
        logic [6:0] roll;
    } t_in_item;

    typedef struct packed {
        logic       cell_state;
        logic [3:0] closed_count;
    } t_out_item;

    // Three neighbours of one row word around the addressed column.
    typedef struct packed {
        logic left_closed;
        logic mid_closed;
        logic right_closed;
        logic mid_value;
    } t_tap;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_MID,
        ST_RD_DN,
        ST_FINISH
    } t_state;

endpackage

// ----- rtl/cacu_grid_mem.sv -----
// Grid storage: one word per row, one bit per cell, bit-wise write enable.
// Synchronous read with registered data; depends on nothing.
module cacu_grid_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(WIDTH)-1:0] i_wr_bit,
    input  logic                     i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single-cell write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_bit] <= i_wr_data;
        end
    end

    // Row word read into a data register.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/cacu_row_tap.sv -----
// Picks the addressed column and its two side neighbours out of a row word.
// Depends on cacu_pkg for the tap struct.
module cacu_row_tap #(
    parameter int MAX_COLS = 128,
    parameter int CNW = 8
) (
    input  logic [MAX_COLS-1:0] i_word,
    input  logic [6:0]          i_col,
    input  logic [CNW-1:0]      i_cols_use,
    input  logic                i_row_ok,
    output cacu_pkg::t_tap      o_tap
);
    import cacu_pkg::*;

    localparam int CIW = $clog2(MAX_COLS);

    logic [CNW-1:0] col_w;
    logic [CNW-1:0] left_w;
    logic [CNW-1:0] right_w;
    logic           left_ok;
    logic           right_ok;

    // Column positions and their bounds.
    assign col_w    = CNW'(i_col);
    assign left_w   = col_w - CNW'(1);
    assign right_w  = col_w + CNW'(1);
    assign left_ok  = i_row_ok && (col_w != '0);
    assign right_ok = i_row_ok && (right_w < i_cols_use);

    // Closed flags are masked by the bounds; the middle value is the cell itself.
    always_comb begin
        o_tap.left_closed  = left_ok && !i_word[left_w[CIW-1:0]];
        o_tap.mid_closed   = i_row_ok && !i_word[col_w[CIW-1:0]];
        o_tap.right_closed = right_ok && !i_word[right_w[CIW-1:0]];
        o_tap.mid_value    = i_word[col_w[CIW-1:0]];
    end

endmodule

// ----- rtl/cave_automaton_cell_update_core.sv -----
// Top level of the cave cell update core: configuration, sequencer, result register.
// Depends on cacu_pkg, cacu_grid_mem and cacu_row_tap.
//
//  Channel   Direction  Handshake                     Payload
//  in        input      i_in_valid / o_in_ready       i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready     o_out_item (t_out_item)
//  cfg       input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// A seed item, or any item outside the grid, is answered in the cycle after acceptance;
// only an in-grid seed is written. Update and read items fetch three row words in turn
// through the single read port of the grid memory, in ST_IDLE, ST_RD_MID and ST_RD_DN.
// Reset clears control and configuration only; the grid needs no clearing pass.
// A new transaction is taken only when the result register is empty or being emptied.
module cave_automaton_cell_update_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  cacu_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output cacu_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [cacu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cacu_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import cacu_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int BW  = $clog2(MAX_COLS);
    localparam int RNW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int CNW = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;

    // Configuration registers.
    logic [6:0] r_grid_rows;
    logic [7:0] r_grid_cols;
    logic [6:0] r_seed_threshold;
    logic [3:0] r_closed_limit;
    logic       r_flip_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows      <= 7'd64;
            r_grid_cols      <= 8'd128;
            r_seed_threshold <= 7'd0;
            r_closed_limit   <= 4'd4;
            r_flip_state     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS:      r_grid_rows      <= i_cfg_data[6:0];
                CFG_GRID_COLS:      r_grid_cols      <= i_cfg_data;
                CFG_SEED_THRESHOLD: r_seed_threshold <= i_cfg_data[6:0];
                CFG_CLOSED_LIMIT:   r_closed_limit   <= i_cfg_data[3:0];
                CFG_FLIP_STATE:     r_flip_state     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Grid size in use, saturated to the storage.
    logic [RNW-1:0] rows_use;
    logic [CNW-1:0] cols_use;

    assign rows_use = (RNW'(r_grid_rows) > RNW'(MAX_ROWS)) ? RNW'(MAX_ROWS)
                                                            : RNW'(r_grid_rows);
    assign cols_use = (CNW'(r_grid_cols) > CNW'(MAX_COLS)) ? CNW'(MAX_COLS)
                                                            : CNW'(r_grid_cols);

    // Incoming transaction decode.
    t_state         r_state;
    t_state         n_state;
    t_in_item       r_item;
    logic           r_out_valid;
    t_out_item      r_out_item;
    logic [RNW-1:0] in_row_w;
    logic [CNW-1:0] in_col_w;
    logic [RNW-1:0] in_up_w;
    logic           in_bounds;
    logic           in_accept;
    logic           go_update;
    logic           seed_cell;

    assign in_row_w   = RNW'(i_in_item.row);
    assign in_col_w   = CNW'(i_in_item.col);
    assign in_up_w    = in_row_w - RNW'(1);
    assign in_bounds  = (in_row_w < rows_use) && (in_col_w < cols_use);
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;
    assign go_update  = in_accept && in_bounds && (i_in_item.kind != KIND_SEED);
    assign seed_cell  = (i_in_item.roll < r_seed_threshold) ? r_flip_state : !r_flip_state;

    // Held item for multi-cycle work.
    logic [RNW-1:0] r_row_w;
    logic [RNW-1:0] dn_row_w;
    logic [CNW-1:0] r_col_w;

    assign r_row_w  = RNW'(r_item.row);
    assign dn_row_w = r_row_w + RNW'(1);
    assign r_col_w  = CNW'(r_item.col);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
    end

    // Sequencer state register and next state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:   n_state = go_update ? ST_RD_MID : ST_IDLE;
            ST_RD_MID: n_state = ST_RD_DN;
            ST_RD_DN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
        endcase
    end

    // Memory and tap controls per state.
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [MAX_COLS-1:0] rd_data;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [BW-1:0]  wr_bit;
    logic           wr_data;
    logic           tap_row_ok;
    logic           upd_cell;

    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = in_up_w[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = in_row_w[AW-1:0];
        wr_bit     = in_col_w[BW-1:0];
        wr_data    = seed_cell;
        tap_row_ok = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                rd_en = go_update;
                wr_en = in_accept && in_bounds && (i_in_item.kind == KIND_SEED);
            end
            ST_RD_MID: begin
                rd_en      = 1'b1;
                rd_addr    = r_row_w[AW-1:0];
                tap_row_ok = (r_row_w != '0);
            end
            ST_RD_DN: begin
                rd_en      = 1'b1;
                rd_addr    = dn_row_w[AW-1:0];
                tap_row_ok = 1'b1;
            end
            ST_FINISH: begin
                tap_row_ok = (dn_row_w < rows_use);
                wr_en      = (r_item.kind == KIND_UPDATE);
                wr_addr    = r_row_w[AW-1:0];
                wr_bit     = r_col_w[BW-1:0];
                wr_data    = upd_cell;
            end
        endcase
    end

    cacu_grid_mem #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_bit  (wr_bit),
        .i_wr_data (wr_data)
    );

    t_tap tap;

    cacu_row_tap #(
        .MAX_COLS (MAX_COLS),
        .CNW      (CNW)
    ) u_row_tap (
        .i_word     (rd_data),
        .i_col      (r_item.col),
        .i_cols_use (cols_use),
        .i_row_ok   (tap_row_ok),
        .o_tap      (tap)
    );

    // Neighbourhood taps of the upper and middle rows.
    t_tap r_up_tap;
    t_tap r_mid_tap;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_MID) begin
            r_up_tap <= tap;
        end
        if (r_state == ST_RD_DN) begin
            r_mid_tap <= tap;
        end
    end

    // Closed neighbour count over the eight positions; the center is excluded.
    logic [7:0] closed_flags;
    logic [3:0] closed_count;

    assign closed_flags = {r_up_tap.left_closed, r_up_tap.mid_closed, r_up_tap.right_closed,
                           r_mid_tap.left_closed, r_mid_tap.right_closed,
                           tap.left_closed, tap.mid_closed, tap.right_closed};

    always_comb begin
        closed_count = 4'd0;
        for (int i = 0; i < 8; i++) begin
            closed_count = closed_count + 4'(closed_flags[i]);
        end
    end

    assign upd_cell = !(closed_count > r_closed_limit);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_accept && !go_update) || (r_state == ST_FINISH)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            r_out_item.cell_state   <= (r_item.kind == KIND_UPDATE) ? upd_cell
                                                                   : r_mid_tap.mid_value;
            r_out_item.closed_count <= closed_count;
        end else if (in_accept && !go_update) begin
            r_out_item.cell_state   <= in_bounds && seed_cell;
            r_out_item.closed_count <= 4'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/cacu_checker.sv -----
// Port-level checks of the cave cell update core, bound to the top level.
// Depends on cacu_pkg and the assertion macro header.
`include "cave_automaton_cell_update_core_macros.svh"

module cacu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input cacu_pkg::t_in_item              i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input cacu_pkg::t_out_item             o_out_item
);
    import cacu_pkg::*;

    logic in_acc;
    logic seed_acc;
    logic out_stall;
    logic zero_count;
    logic count_ok;

    // Handshake and payload terms seen at the ports.
    assign in_acc     = i_in_valid && o_in_ready;
    assign seed_acc   = in_acc && (i_in_item.kind == KIND_SEED);
    assign out_stall  = o_out_valid && !i_out_ready;
    assign zero_count = (o_out_item.closed_count == 4'd0);
    assign count_ok   = (o_out_item.closed_count <= MAX_NEIGHBOURS);

    // A stalled result holds.
    `CACU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item))

    // An accepted transaction either answers at once or blocks the input.
    `CACU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, o_out_valid || !o_in_ready)

    // A seed answers in the next cycle with a zero count.
    `CACU_ASSERT_NEXT(a_seed_zero, i_clk, i_rst_n, seed_acc, o_out_valid && zero_count)

    // A count never exceeds the neighbourhood.
    `CACU_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_out_valid, count_ok)

endmodule

bind cave_automaton_cell_update_core cacu_checker u_cacu_checker (.*);
